// File: hdl/vec3_normalize_assert.svh
// Assertion macros for vec3_normalize
`ifndef VEC3_NORMALIZE_ASSERT_SVH
`define VEC3_NORMALIZE_ASSERT_SVH

// condition that must hold at every edge outside reset
`define VN_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication checked from the same edge
`define VN_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/vn_pkg.sv
package vn_pkg;

    localparam int VN_IN_W  = 32;   // component width
    localparam int VN_SQ_W  = 64;   // exact sum of squares
    localparam int VN_LEN_W = 32;   // floor sqrt of the sum
    localparam int VN_Q_W   = 17;   // quotient magnitude, up to 65536
    localparam int VN_OUT_W = 18;   // signed result
    localparam int VN_FRAC  = 16;   // Q16.16 fraction bits

    typedef struct packed {
        logic [VN_IN_W-1:0] mag_x;
        logic [VN_IN_W-1:0] mag_y;
        logic [VN_IN_W-1:0] mag_z;
        logic               neg_x;
        logic               neg_y;
        logic               neg_z;
    } t_side;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_dtag;

endpackage

// File: hdl/vn_sqrt.sv
// Floor square root, one result bit per stage
module vn_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [vn_pkg::VN_SQ_W-1:0]    i_rad,
    input  vn_pkg::t_side                 i_side,
    output logic                          o_valid,
    output logic [vn_pkg::VN_LEN_W-1:0]   o_root,
    output vn_pkg::t_side                 o_side
);

    localparam int NS    = vn_pkg::VN_LEN_W;
    localparam int REM_W = vn_pkg::VN_LEN_W + 1;
    localparam int ACC_W = REM_W + 2;

    logic                          r_v    [1:NS];
    logic [REM_W-1:0]              r_rem  [1:NS];
    logic [vn_pkg::VN_LEN_W-1:0]   r_root [1:NS];
    logic [vn_pkg::VN_SQ_W-1:0]    r_src  [1:NS];
    vn_pkg::t_side                 r_side [1:NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            logic                        w_v;
            logic [REM_W-1:0]            w_rem;
            logic [vn_pkg::VN_LEN_W-1:0] w_root;
            logic [vn_pkg::VN_SQ_W-1:0]  w_src;
            vn_pkg::t_side               w_side;
            logic [ACC_W-1:0]            n_acc;
            logic [ACC_W-1:0]            n_try;
            logic [REM_W-1:0]            n_rem;
            logic [vn_pkg::VN_LEN_W-1:0] n_root;

            if (k == 0) begin : g_first
                assign w_v    = i_valid;
                assign w_rem  = '0;
                assign w_root = '0;
                assign w_src  = i_rad;
                assign w_side = i_side;
            end else begin : g_next
                assign w_v    = r_v[k];
                assign w_rem  = r_rem[k];
                assign w_root = r_root[k];
                assign w_src  = r_src[k];
                assign w_side = r_side[k];
            end

            always_comb begin
                n_acc = {w_rem, w_src[vn_pkg::VN_SQ_W-1 -: 2]};
                n_try = {1'b0, w_root, 2'b01};
                if (n_acc >= n_try) begin
                    n_rem  = REM_W'(n_acc - n_try);
                    n_root = {w_root[vn_pkg::VN_LEN_W-2:0], 1'b1};
                end else begin
                    n_rem  = n_acc[REM_W-1:0];
                    n_root = {w_root[vn_pkg::VN_LEN_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_v[k+1] <= w_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1]  <= n_rem;
                    r_root[k+1] <= n_root;
                    r_src[k+1]  <= {w_src[vn_pkg::VN_SQ_W-3:0], 2'b00};
                    r_side[k+1] <= w_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[NS];
    assign o_root  = r_root[NS];
    assign o_side  = r_side[NS];

endmodule

// File: hdl/vn_div.sv
// Restoring divider, (mag << 16) / len, one quotient bit per stage
module vn_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [vn_pkg::VN_IN_W-1:0]    i_mag,
    input  logic [vn_pkg::VN_LEN_W-1:0]   i_len,
    input  vn_pkg::t_dtag                 i_tag,
    output logic                          o_valid,
    output logic [vn_pkg::VN_Q_W-1:0]     o_quo,
    output vn_pkg::t_dtag                 o_tag
);

    localparam int NS    = vn_pkg::VN_Q_W;
    localparam int REM_W = vn_pkg::VN_LEN_W;
    localparam int ACC_W = REM_W + 1;

    logic                          r_v   [1:NS];
    logic [REM_W-1:0]              r_rem [1:NS];
    logic [NS-1:0]                 r_quo [1:NS];
    logic [NS-1:0]                 r_src [1:NS];
    logic [vn_pkg::VN_LEN_W-1:0]   r_len [1:NS];
    vn_pkg::t_dtag                 r_tag [1:NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            logic                        w_v;
            logic [REM_W-1:0]            w_rem;
            logic [NS-1:0]               w_quo;
            logic [NS-1:0]               w_src;
            logic [vn_pkg::VN_LEN_W-1:0] w_len;
            vn_pkg::t_dtag               w_tag;
            logic [ACC_W-1:0]            n_acc;
            logic [REM_W-1:0]            n_rem;
            logic                        n_bit;

            if (k == 0) begin : g_first
                // top bits of the numerator start below len, so 17 steps suffice
                assign w_v   = i_valid;
                assign w_rem = {1'b0, i_mag[vn_pkg::VN_IN_W-1:1]};
                assign w_quo = '0;
                assign w_src = {i_mag[0], {(NS-1){1'b0}}};
                assign w_len = i_len;
                assign w_tag = i_tag;
            end else begin : g_next
                assign w_v   = r_v[k];
                assign w_rem = r_rem[k];
                assign w_quo = r_quo[k];
                assign w_src = r_src[k];
                assign w_len = r_len[k];
                assign w_tag = r_tag[k];
            end

            always_comb begin
                n_acc = {w_rem, w_src[NS-1]};
                n_bit = (n_acc >= {1'b0, w_len});
                if (n_bit) begin
                    n_rem = REM_W'(n_acc - {1'b0, w_len});
                end else begin
                    n_rem = n_acc[REM_W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_v[k+1] <= w_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= n_rem;
                    r_quo[k+1] <= {w_quo[NS-2:0], n_bit};
                    r_src[k+1] <= {w_src[NS-2:0], 1'b0};
                    r_len[k+1] <= w_len;
                    r_tag[k+1] <= w_tag;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[NS];
    assign o_quo   = r_quo[NS];
    assign o_tag   = r_tag[NS];

endmodule

// File: hdl/vec3_normalize.sv
// vec3_normalize: scales a signed Q16.16 3D vector to unit length.
// Input channel: i_valid / o_stall carry i_in_x, i_in_y, i_in_z. A transfer
//   happens on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry o_unit_x/y/z (signed Q2.16,
//   -65536..65536, truncated toward zero) and o_zero_length.
// A zero vector gives zero components with o_zero_length set.
// Pipeline, from input transfer to the output: magnitude, squaring, two
//   adder stages, the 32-stage square root (one root bit per stage), the
//   17-stage dividers (one quotient bit per stage) and the output register.
// Throughput: one vector per cycle while the receiver does not stall.
// Stall: the whole pipeline holds as one while a result waits under
//   i_stall; o_stall then rises and nothing is lost or repeated. Bubbles
//   keep moving while the output register is empty.
// Reset: synchronous, active low; clears every valid bit, so the block
//   comes out empty. Data registers are not reset.
module vec3_normalize (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [vn_pkg::VN_IN_W-1:0]   i_in_x,
    input  logic signed [vn_pkg::VN_IN_W-1:0]   i_in_y,
    input  logic signed [vn_pkg::VN_IN_W-1:0]   i_in_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [vn_pkg::VN_OUT_W-1:0]  o_unit_x,
    output logic signed [vn_pkg::VN_OUT_W-1:0]  o_unit_y,
    output logic signed [vn_pkg::VN_OUT_W-1:0]  o_unit_z,
    output logic                                o_zero_length
);

`include "vec3_normalize_assert.svh"

    localparam int IW = vn_pkg::VN_IN_W;
    localparam int SW = vn_pkg::VN_SQ_W;

    // global advance: hold only when a result is waiting and stalled
    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // stage 1: magnitudes and signs
    logic          r_v1;
    vn_pkg::t_side r_side1;

    function automatic logic [IW-1:0] f_mag(input logic [IW-1:0] a);
        logic [IW-1:0] v;
        v = a[IW-1] ? IW'(~a + 1'b1) : a;
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side1.mag_x <= f_mag(i_in_x);
            r_side1.mag_y <= f_mag(i_in_y);
            r_side1.mag_z <= f_mag(i_in_z);
            r_side1.neg_x <= i_in_x[IW-1];
            r_side1.neg_y <= i_in_y[IW-1];
            r_side1.neg_z <= i_in_z[IW-1];
        end
    end

    // stage 2: exact squares, one multiplier per component
    logic          r_v2;
    vn_pkg::t_side r_side2;
    logic [SW-1:0] r_sqx;
    logic [SW-1:0] r_sqy;
    logic [SW-1:0] r_sqz;

    // stages 3 and 4: sum of squares, one add per stage
    logic          r_v3;
    vn_pkg::t_side r_side3;
    logic [SW-1:0] r_sxy;
    logic [SW-1:0] r_sz;
    logic          r_v4;
    vn_pkg::t_side r_side4;
    logic [SW-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqx   <= SW'(r_side1.mag_x * r_side1.mag_x);
            r_sqy   <= SW'(r_side1.mag_y * r_side1.mag_y);
            r_sqz   <= SW'(r_side1.mag_z * r_side1.mag_z);
            r_side2 <= r_side1;
            r_sxy   <= SW'(r_sqx + r_sqy);   // <= 2^63, no carry out
            r_sz    <= r_sqz;
            r_side3 <= r_side2;
            r_sum   <= SW'(r_sxy + r_sz);    // <= 3 * 2^62
            r_side4 <= r_side3;
        end
    end

    // square root
    logic                          w_sv;
    logic [vn_pkg::VN_LEN_W-1:0]   w_len;
    vn_pkg::t_side                 w_sside;

    vn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_rad   (r_sum),
        .i_side  (r_side4),
        .o_valid (w_sv),
        .o_root  (w_len),
        .o_side  (w_sside)
    );

    // three divider lanes sharing the length
    logic                      w_zero;
    vn_pkg::t_dtag             w_tx;
    vn_pkg::t_dtag             w_ty;
    vn_pkg::t_dtag             w_tz;
    logic                      w_dvx;
    logic                      w_dvy;
    logic                      w_dvz;
    logic [vn_pkg::VN_Q_W-1:0] w_qx;
    logic [vn_pkg::VN_Q_W-1:0] w_qy;
    logic [vn_pkg::VN_Q_W-1:0] w_qz;
    vn_pkg::t_dtag             w_ox;
    vn_pkg::t_dtag             w_oy;
    vn_pkg::t_dtag             w_oz;

    assign w_zero = (w_len == '0);
    assign w_tx   = '{neg: w_sside.neg_x, zero: w_zero};
    assign w_ty   = '{neg: w_sside.neg_y, zero: w_zero};
    assign w_tz   = '{neg: w_sside.neg_z, zero: w_zero};

    vn_div u_div_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (w_sv), .i_mag (w_sside.mag_x), .i_len (w_len), .i_tag (w_tx),
        .o_valid (w_dvx), .o_quo (w_qx), .o_tag (w_ox)
    );

    vn_div u_div_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (w_sv), .i_mag (w_sside.mag_y), .i_len (w_len), .i_tag (w_ty),
        .o_valid (w_dvy), .o_quo (w_qy), .o_tag (w_oy)
    );

    vn_div u_div_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_valid (w_sv), .i_mag (w_sside.mag_z), .i_len (w_len), .i_tag (w_tz),
        .o_valid (w_dvz), .o_quo (w_qz), .o_tag (w_oz)
    );

    // output stage: sign applied after truncation, zero vector forced to 0
    function automatic logic [vn_pkg::VN_OUT_W-1:0] f_sign(
        input logic [vn_pkg::VN_Q_W-1:0] q,
        input vn_pkg::t_dtag             t
    );
        logic [vn_pkg::VN_OUT_W-1:0] m;
        m = {1'b0, q};
        if (t.zero) begin
            return '0;
        end
        return t.neg ? vn_pkg::VN_OUT_W'(~m + 1'b1) : m;
    endfunction

    logic                               r_ov;
    logic [vn_pkg::VN_OUT_W-1:0]        r_ux;
    logic [vn_pkg::VN_OUT_W-1:0]        r_uy;
    logic [vn_pkg::VN_OUT_W-1:0]        r_uz;
    logic                               r_zl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_dvx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ux <= f_sign(w_qx, w_ox);
            r_uy <= f_sign(w_qy, w_oy);
            r_uz <= f_sign(w_qz, w_oz);
            r_zl <= w_ox.zero;
        end
    end

    assign o_valid       = r_ov;
    assign o_unit_x      = r_ux;
    assign o_unit_y      = r_uy;
    assign o_unit_z      = r_uz;
    assign o_zero_length = r_zl;

    `VN_ALWAYS(a_lanes_aligned, i_clk, i_rst_n,
        (w_dvx == w_dvy) && (w_dvx == w_dvz), "divider lanes out of step")
    `VN_IMPLIES(a_zero_clears, i_clk, i_rst_n, o_valid && o_zero_length,
        (o_unit_x == '0) && (o_unit_y == '0) && (o_unit_z == '0),
        "zero vector gave non-zero components")
    `VN_IMPLIES(a_unit_range, i_clk, i_rst_n, o_valid && !o_zero_length,
        (o_unit_x >= -18'sd65536) && (o_unit_x <= 18'sd65536) &&
        (o_unit_y >= -18'sd65536) && (o_unit_y <= 18'sd65536) &&
        (o_unit_z >= -18'sd65536) && (o_unit_z <= 18'sd65536),
        "normalised component out of range")

endmodule

// File: sim/vec3_normalize_checker.sv
`timescale 1ns / 1ps

module vec3_normalize_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_stall_in,
    input  logic signed [vn_pkg::VN_IN_W-1:0]   i_in_x,
    input  logic signed [vn_pkg::VN_IN_W-1:0]   i_in_y,
    input  logic signed [vn_pkg::VN_IN_W-1:0]   i_in_z,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [vn_pkg::VN_OUT_W-1:0]  i_unit_x,
    input  logic signed [vn_pkg::VN_OUT_W-1:0]  i_unit_y,
    input  logic signed [vn_pkg::VN_OUT_W-1:0]  i_unit_z,
    input  logic                                i_zero_length,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    typedef struct packed {
        logic [vn_pkg::VN_OUT_W-1:0] ux;
        logic [vn_pkg::VN_OUT_W-1:0] uy;
        logic [vn_pkg::VN_OUT_W-1:0] uz;
        logic                        zl;
    } t_unit_vec;

    t_unit_vec unit_queue[$];

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic logic [vn_pkg::VN_OUT_W-1:0] unit_comp(input logic [63:0] mag,
                                                              input logic neg,
                                                              input logic [63:0] len);
        logic [63:0] q;
        q = (mag << vn_pkg::VN_FRAC) / len;
        if (neg) q = -q;
        return q[vn_pkg::VN_OUT_W-1:0];
    endfunction

    function automatic t_unit_vec normalise(input logic [31:0] x,
                                            input logic [31:0] y,
                                            input logic [31:0] z);
        t_unit_vec r;
        logic [63:0] mx, my, mz, len;
        mx = x[31] ? {32'd0, -x} : {32'd0, x};
        my = y[31] ? {32'd0, -y} : {32'd0, y};
        mz = z[31] ? {32'd0, -z} : {32'd0, z};
        len = floor_sqrt(mx * mx + my * my + mz * mz);
        if (len == 0) begin
            r = '0;
            r.zl = 1'b1;
        end else begin
            r.ux = unit_comp(mx, x[31], len);
            r.uy = unit_comp(my, y[31], len);
            r.uz = unit_comp(mz, z[31], len);
            r.zl = 1'b0;
        end
        return r;
    endfunction

    assign o_pending = unit_queue.size();

    always @(posedge i_clk) begin
        t_unit_vec exp_v;
        if (i_rst_n && i_valid && !i_stall_in)
            unit_queue.push_back(normalise(i_in_x, i_in_y, i_in_z));
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (unit_queue.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d zl=%0b", $time,
                         i_unit_x, i_unit_y, i_unit_z, i_zero_length);
                o_fail_count <= o_fail_count + 1;
            end else begin
                exp_v = unit_queue.pop_front();
                if ({i_unit_x, i_unit_y, i_unit_z, i_zero_length} !== exp_v) begin
                    $display("%0t: mismatch exp x=%0d y=%0d z=%0d zl=%0b",
                             $time, $signed(exp_v.ux), $signed(exp_v.uy),
                             $signed(exp_v.uz), exp_v.zl);
                    $display("%0t:          got x=%0d y=%0d z=%0d zl=%0b",
                             $time, i_unit_x, i_unit_y, i_unit_z, i_zero_length);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end
endmodule

// File: sim/vec3_normalize_test.sv
`timescale 1ns / 1ps

module vec3_normalize_test;

    localparam int N_RANDOM = 1200;
    localparam int DRAIN_CYCLES = 80;   // beyond the pipeline latency

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b1;
    logic signed [vn_pkg::VN_IN_W-1:0] i_in_x = '0, i_in_y = '0, i_in_z = '0;
    logic o_stall, o_valid, o_zero_length;
    logic signed [vn_pkg::VN_OUT_W-1:0] o_unit_x, o_unit_y, o_unit_z;
    int fail_count, pending;
    bit hold_off_done = 1'b0;

    always #10 i_clk = ~i_clk;

    vec3_normalize u_top (.*);

    vec3_normalize_checker u_check (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall),
        .i_in_x, .i_in_y, .i_in_z,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_unit_x(o_unit_x), .i_unit_y(o_unit_y), .i_unit_z(o_unit_z),
        .i_zero_length(o_zero_length),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Random component: mostly modest magnitudes, sometimes full range,
    // sometimes tiny or zero so short vectors are exercised.
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'(int'($urandom_range(0, 8)) - 4);
            2: return 32'(int'($urandom_range(0, 2000)) - 1000);
            3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
            4: return ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return 32'(int'($urandom_range(0, 32'h7ff_ffff)) - 32'h400_0000);
        endcase
    endfunction

    // One transfer: optional gap, then hold the payload until accepted.
    task automatic send_vec(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_x  <= x;
        i_in_y  <= y;
        i_in_z  <= z;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Receiver: random stall lengths, with stall-free stretches, plus one
    // long hold-off that backs the pipeline up into the input.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!hold_off_done && $time > 3000) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off_done = 1'b1;
            end
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
            if (($time / 20000) % 4 == 1) n = 0;
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    initial begin
        logic [31:0] lim[6];
        int waited;
        lim = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero vector, single-bit, axes, extremes, mixed signs.
        send_vec(0, 0, 0);
        send_vec(1, 0, 0);
        send_vec(0, 32'hffff_ffff, 0);
        send_vec(0, 0, 32'h8000_0000);
        send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_vec(32'h7fff_ffff, 32'h8000_0000, 32'h0);
        send_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
        send_vec(32'haaaa_aaaa, 32'h5555_5555, 32'hf0f0_f0f0);
        send_vec(3, 4, 0);
        send_vec(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        for (int k = 0; k < 12; k++)
            send_vec(lim[$urandom_range(0, 5)], lim[$urandom_range(0, 5)],
                     lim[$urandom_range(0, 5)]);

        for (int k = 0; k < N_RANDOM; k++)
            send_vec(rand_comp(), rand_comp(), rand_comp());
        i_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog, far above the slowest legal run.
    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
